[rtl/core/mtt_pkg.sv]
package mtt_pkg;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);

   localparam logic [7:0] CHAR_LT   = 8'h3C;
   localparam logic [7:0] CHAR_GT   = 8'h3E;
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   typedef enum logic [1:0] {
      KIND_TEXT    = 2'd0,
      KIND_TAGBYTE = 2'd1,
      KIND_TAGEND  = 2'd2,
      KIND_DOCEND  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   out_kind;
      logic       tag_incomplete;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [CNT_W-1:0]             cnt;
      logic                         eod;
   } bundle_type;

   function automatic logic [7:0] opener_char(input logic [1:0] idx);
      opener_char = (idx == 2'd0) ? CHAR_BANG : CHAR_DASH;
   endfunction

endpackage

[rtl/core/mtt_decode.sv]
module mtt_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output mtt_pkg::bundle_type bundle
);
   import mtt_pkg::*;

   typedef enum logic [2:0] {
      MODE_TEXT    = 3'd0,
      MODE_OPEN    = 3'd1,
      MODE_TAG     = 3'd2,
      MODE_COMMENT = 3'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [1:0] match_ff, match_in;
   logic [1:0] dash_ff, dash_in;
   logic       emit_text_ff;

   function automatic bundle_type add_result(input bundle_type b, input logic [7:0] val,
                                             input kind_type kind, input logic inc);
      result_type r;
      r.out_byte       = val;
      r.out_kind       = kind;
      r.tag_incomplete = inc;
      b.res[b.cnt[SLOT_W-1:0]] = r;
      b.cnt = b.cnt + CNT_W'(1);
      return b;
   endfunction

   always_comb begin
      bundle_type b;
      b        = '0;
      mode_in  = mode_ff;
      match_in = match_ff;
      dash_in  = dash_ff;
      case (mode_ff)
         MODE_OPEN: begin
            if (match_ff != 2'd3 && data_byte == opener_char(match_ff)) begin
               if (match_ff == 2'd2) begin
                  mode_in  = MODE_COMMENT;
                  match_in = 2'd0;
                  dash_in  = 2'd0;
               end else begin
                  match_in = match_ff + 2'd1;
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < match_ff) begin
                     b = add_result(b, opener_char(2'(i)), KIND_TAGBYTE, 1'b0);
                  end
               end
               match_in = 2'd0;
               if (data_byte == CHAR_GT) begin
                  mode_in = MODE_TEXT;
                  b = add_result(b, 8'd0, KIND_TAGEND, 1'b0);
               end else begin
                  mode_in = MODE_TAG;
                  b = add_result(b, data_byte, KIND_TAGBYTE, 1'b0);
               end
            end
         end
         MODE_TAG: begin
            if (data_byte == CHAR_GT) begin
               mode_in = MODE_TEXT;
               b = add_result(b, 8'd0, KIND_TAGEND, 1'b0);
            end else begin
               b = add_result(b, data_byte, KIND_TAGBYTE, 1'b0);
            end
         end
         MODE_COMMENT: begin
            if (data_byte == CHAR_DASH) begin
               if (dash_ff < 2'd2) begin
                  dash_in = dash_ff + 2'd1;
               end
            end else if (data_byte == CHAR_GT && dash_ff >= 2'd2) begin
               mode_in = MODE_TEXT;
               dash_in = 2'd0;
            end else begin
               dash_in = 2'd0;
            end
         end
         default: begin
            if (data_byte == CHAR_LT) begin
               mode_in  = MODE_OPEN;
               match_in = 2'd0;
            end else begin
               mode_in = MODE_TEXT;
               if (emit_text_ff) begin
                  b = add_result(b, data_byte, KIND_TEXT, 1'b0);
               end
            end
         end
      endcase

      if (last_byte) begin
         if (mode_in == MODE_OPEN) begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < match_in) begin
                  b = add_result(b, opener_char(2'(i)), KIND_TAGBYTE, 1'b0);
               end
            end
            b = add_result(b, 8'd0, KIND_TAGEND, 1'b1);
         end else if (mode_in == MODE_TAG) begin
            b = add_result(b, 8'd0, KIND_TAGEND, 1'b1);
         end
         if (b.cnt == '0) begin
            b = add_result(b, 8'd0, KIND_DOCEND, 1'b0);
         end
         b.eod    = 1'b1;
         mode_in  = MODE_TEXT;
         match_in = 2'd0;
         dash_in  = 2'd0;
      end
      bundle = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         match_ff     <= 2'd0;
         dash_ff      <= 2'd0;
         emit_text_ff <= 1'b1;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            match_ff <= match_in;
            dash_ff  <= dash_in;
         end
         if (csr_wr_en) begin
            emit_text_ff <= csr_wr_data;
         end
      end
   end

endmodule

[rtl/core/mtt_outbuf.sv]
module mtt_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mtt_pkg::bundle_type bundle,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mtt_pkg::result_type rsp_res,
   output logic                rsp_eod,
   output logic                rsp_last
);
   import mtt_pkg::*;

   result_type [MAX_RESULTS-1:0] slot_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         eod_ff;
   logic                         pop;

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_last   = (cnt_ff == CNT_W'(1));
   assign rsp_res    = slot_ff[0];
   assign rsp_eod    = eod_ff && rsp_last;
   assign can_load   = (cnt_ff == '0) || (rsp_last && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.res;
         eod_ff  <= bundle.eod;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

endmodule

[rtl/core/markup_tag_tokenizer_unit.sv]
// channel  dir  tdata           tuser                                   tlast
// req_     in   data_byte[7:0]  -                                       last_byte
// rsp_     out  out_byte[7:0]   out_kind[1:0] tag_incomplete eod [3]    run_last
// csr_     in   csr_wr_data = emit_text, written when csr_wr_en is high
// an item yields zero to four results, sent one per cycle while rsp_tready is high,
// from the cycle after it is taken; an item with n results holds the result register
// until all n are taken, stalling while rsp_tready is low; an item with no result
// holds nothing; the next item is taken while the final result of the previous one is taken
// synchronous active-high reset: text mode, emit_text = 1, no results held
module markup_tag_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic [3:0] rsp_tuser,    // out_kind[1:0], tag_incomplete, end_of_document
   output logic       rsp_tlast
);
   import mtt_pkg::*;

   bundle_type bundle;
   result_type rsp_res;
   logic       accept;
   logic       can_load;
   logic       rsp_eod;

   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;

   mtt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .bundle      (bundle)
   );

   mtt_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle     (bundle),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res),
      .rsp_eod    (rsp_eod),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_res.out_byte;
   assign rsp_tuser = {rsp_eod, rsp_res.tag_incomplete, rsp_res.out_kind};

endmodule
